>>> src/cpt_pkg.sv
// cpt_pkg: command and status codes shared by the permutation table channels and core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 2;

    typedef logic [ACTION_BITS-1:0] action_t;
    typedef logic [STATUS_BITS-1:0] status_t;

    localparam action_t ACT_ADD   = 2'd0;
    localparam action_t ACT_CLOSE = 2'd1;
    localparam action_t ACT_QUERY = 2'd2;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_EMPTY  = 2'd1;
    localparam status_t ST_SINGLE = 2'd2;

    // occupancy of the open cycle
    typedef logic [1:0] open_len_t;

    localparam open_len_t LEN_NONE = 2'd0;
    localparam open_len_t LEN_ONE  = 2'd1;
    localparam open_len_t LEN_MANY = 2'd2;

endpackage

`default_nettype wire

>>> src/cpt_cmd_if.sv
// cpt_cmd_if: command channel (action and literal) with valid/ready handshake
// depends on cpt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cpt_cmd_if
    import cpt_pkg::*;
#(
    parameter int LITERAL_BITS = 10
);
    logic                    valid;
    logic                    ready;
    action_t                 action;
    logic [LITERAL_BITS-1:0] literal;

    modport source (output valid, output action, output literal, input ready);
    modport sink   (input valid, input action, input literal, output ready);
endinterface

`default_nettype wire

>>> src/cpt_rsp_if.sv
// cpt_rsp_if: response channel carrying image, inverse, trivial flags and status
// depends on cpt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cpt_rsp_if
    import cpt_pkg::*;
#(
    parameter int LITERAL_BITS = 10
);
    logic                    valid;
    logic                    ready;
    logic [LITERAL_BITS-1:0] image;
    logic [LITERAL_BITS-1:0] inverse;
    logic                    image_trivial;
    logic                    inverse_trivial;
    status_t                 status;

    modport source (output valid, output image, output inverse, output image_trivial,
                    output inverse_trivial, output status, input ready);
    modport sink   (input valid, input image, input inverse, input image_trivial,
                    input inverse_trivial, input status, output ready);
endinterface

`default_nettype wire

>>> src/cycle_permutation_table_core.sv
// cycle_permutation_table_core: permutation built from cycle notation, image/inverse lookup
// depends on cpt_pkg, cpt_cmd_if, cpt_rsp_if
//
// usage:
//   cmd carries one word per item: add a literal to the open cycle, close the
//   open cycle, or query a literal. every word yields exactly one rsp word.
//   add and close words return zero image/inverse fields and a status; a query
//   returns the image and the preimage of the literal, each flagged trivial
//   (and equal to the literal) when no link was stored for it.
//   each word passes the read stage, then the output register; one word per
//   cycle is taken while rsp keeps draining, set by the single write and
//   registered read port of each table memory.
//   after reset the two tables are swept clear, one entry per cycle, through
//   all 2**LITERAL_BITS entries (1024 at the default); cmd.ready stays low then.
//   when rsp.ready is low, the output register holds its word, a second word
//   waits in the read stage, and cmd.ready drops until space opens again.
`timescale 1ns / 1ps
`default_nettype none

module cycle_permutation_table_core
    import cpt_pkg::*;
#(
    parameter int LITERAL_BITS = 10
)(
    input  wire        clk,
    input  wire        rst_n,
    cpt_cmd_if.sink    cmd,
    cpt_rsp_if.source  rsp
);

    localparam int DEPTH = 1 << LITERAL_BITS;

    typedef logic [LITERAL_BITS-1:0] lit_t;
    // entry: valid flag on top of the stored literal
    typedef logic [LITERAL_BITS:0]   entry_t;

    entry_t img_mem [DEPTH];
    entry_t inv_mem [DEPTH];

    // clearing sweep
    logic      clr_active_reg;
    lit_t      clr_addr_reg;

    // open cycle
    lit_t      first_reg;
    lit_t      prev_reg;
    open_len_t open_len_reg;
    lit_t      first_next;
    lit_t      prev_next;
    open_len_t open_len_next;

    // read stage
    logic      s1_valid_reg;
    action_t   s1_action_reg;
    lit_t      s1_lit_reg;
    status_t   s1_status_reg;
    entry_t    img_rdata_reg;
    entry_t    inv_rdata_reg;

    // output stage
    logic      out_valid_reg;
    lit_t      out_image_reg;
    lit_t      out_inverse_reg;
    logic      out_img_triv_reg;
    logic      out_inv_triv_reg;
    status_t   out_status_reg;

    logic      accept;
    logic      s2_free;
    logic      s1_adv;
    action_t   act;
    lit_t      lit;
    status_t   status_next;

    logic      img_we;
    lit_t      img_waddr;
    entry_t    img_wdata;
    logic      inv_we;
    lit_t      inv_waddr;
    entry_t    inv_wdata;

    assign act     = cmd.action;
    assign lit     = cmd.literal;
    assign s2_free = !out_valid_reg || rsp.ready;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign cmd.ready = !clr_active_reg && (!s1_valid_reg || s2_free);
    assign accept  = cmd.valid && cmd.ready;

    // open cycle bookkeeping, table links and the clearing writes
    always_comb
    begin
        first_next    = first_reg;
        prev_next     = prev_reg;
        open_len_next = open_len_reg;
        status_next   = ST_OK;
        img_we        = 1'b0;
        inv_we        = 1'b0;
        img_waddr     = prev_reg;
        img_wdata     = {1'b1, lit};
        inv_waddr     = lit;
        inv_wdata     = {1'b1, prev_reg};
        case (act)
            ACT_ADD:
            begin
                if (open_len_reg == LEN_NONE)
                begin
                    first_next = lit;
                end
                else
                begin
                    img_we = accept;
                    inv_we = accept;
                end
                prev_next = lit;
                if (open_len_reg == LEN_NONE)
                begin
                    open_len_next = LEN_ONE;
                end
                else
                begin
                    open_len_next = LEN_MANY;
                end
            end
            ACT_CLOSE:
            begin
                if (open_len_reg == LEN_NONE)
                begin
                    status_next = ST_EMPTY;
                end
                else if (open_len_reg == LEN_ONE)
                begin
                    status_next = ST_SINGLE;
                end
                else
                begin
                    // link the last element back to the first
                    img_we    = accept;
                    inv_we    = accept;
                    img_wdata = {1'b1, first_reg};
                    inv_waddr = first_reg;
                end
                open_len_next = LEN_NONE;
            end
            default:
            begin
            end
        endcase
        if (clr_active_reg)
        begin
            img_we    = 1'b1;
            inv_we    = 1'b1;
            img_waddr = clr_addr_reg;
            inv_waddr = clr_addr_reg;
            img_wdata = '0;
            inv_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[img_waddr] <= img_wdata;
        end
        if (accept)
        begin
            img_rdata_reg <= img_mem[lit];
        end
    end

    always_ff @(posedge clk)
    begin
        if (inv_we)
        begin
            inv_mem[inv_waddr] <= inv_wdata;
        end
        if (accept)
        begin
            inv_rdata_reg <= inv_mem[lit];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            first_reg      <= '0;
            prev_reg       <= '0;
            open_len_reg   <= LEN_NONE;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                first_reg    <= first_next;
                prev_reg     <= prev_next;
                open_len_reg <= open_len_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= act;
            s1_lit_reg    <= lit;
            s1_status_reg <= status_next;
        end
    end

    // resolve trivial entries on the way into the output register
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_status_reg <= s1_status_reg;
            if (s1_action_reg == ACT_QUERY)
            begin
                out_img_triv_reg <= !img_rdata_reg[LITERAL_BITS];
                out_inv_triv_reg <= !inv_rdata_reg[LITERAL_BITS];
                out_image_reg    <= img_rdata_reg[LITERAL_BITS] ?
                                    img_rdata_reg[LITERAL_BITS-1:0] : s1_lit_reg;
                out_inverse_reg  <= inv_rdata_reg[LITERAL_BITS] ?
                                    inv_rdata_reg[LITERAL_BITS-1:0] : s1_lit_reg;
            end
            else
            begin
                out_img_triv_reg <= 1'b0;
                out_inv_triv_reg <= 1'b0;
                out_image_reg    <= '0;
                out_inverse_reg  <= '0;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.image           = out_image_reg;
    assign rsp.inverse         = out_inverse_reg;
    assign rsp.image_trivial   = out_img_triv_reg;
    assign rsp.inverse_trivial = out_inv_triv_reg;
    assign rsp.status          = out_status_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !cmd.ready)
        else $error("command accepted during table clear");

    a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |=> (s1_valid_reg && $stable(s1_lit_reg)))
        else $error("read stage lost a word while output was blocked");

    a_status_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |->
        (!rsp.image_trivial && !rsp.inverse_trivial && rsp.image == '0))
        else $error("error status carried query fields");

    a_open_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        open_len_reg == LEN_NONE || open_len_reg == LEN_ONE || open_len_reg == LEN_MANY)
        else $error("open cycle length out of range");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// tb_top: self-checking bench for cycle_permutation_table_core, cycle building and lookups
// depends on cpt_pkg, cpt_cmd_if, cpt_rsp_if and the core; holds its own copy of both tables
`timescale 1ns / 1ps

module tb_top;
    import cpt_pkg::*;

    localparam int LB          = 10;
    localparam int TABLE_DEPTH = 1 << LB;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;

    // action code the core ignores
    localparam action_t ACT_UNUSED = 2'd3;

    typedef logic [LB-1:0] lit_t;

    typedef struct {
        lit_t    image;
        lit_t    inverse;
        logic    image_trivial;
        logic    inverse_trivial;
        status_t status;
    } perm_answer_t;

    typedef enum { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

    logic clk;
    logic rst_n;

    cpt_cmd_if #(.LITERAL_BITS(LB)) cmd_ch ();
    cpt_rsp_if #(.LITERAL_BITS(LB)) rsp_ch ();

    cycle_permutation_table_core #(
        .LITERAL_BITS(LB)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // shadow permutation
    lit_t      img_map [TABLE_DEPTH];
    bit        img_set [TABLE_DEPTH];
    lit_t      inv_map [TABLE_DEPTH];
    bit        inv_set [TABLE_DEPTH];
    lit_t      cyc_head = '0;
    lit_t      cyc_tail = '0;
    open_len_t cyc_len  = LEN_NONE;

    perm_answer_t pending_answers[$];
    perm_answer_t want;

    idle_mode_t idle_mode = IDLE_NONE;
    bit         hold_req  = 1'b0;
    int         n_errors  = 0;
    int         n_words   = 0;
    int         n_queries = 0;
    int         n_cycles  = 0;
    int         n_empty   = 0;
    int         n_single  = 0;
    int         idle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void link_literals(input lit_t from, input lit_t to);
        img_map[from] = to;
        img_set[from] = 1'b1;
        inv_map[to]   = from;
        inv_set[to]   = 1'b1;
    endfunction

    function automatic perm_answer_t predict_answer(input action_t act, input lit_t lit);
        perm_answer_t ans;
        ans = '{image: '0, inverse: '0, image_trivial: 1'b0, inverse_trivial: 1'b0,
                status: ST_OK};
        case (act)
            ACT_ADD:
            begin
                if (cyc_len == LEN_NONE)
                    cyc_head = lit;
                else
                    link_literals(cyc_tail, lit);
                cyc_tail = lit;
                if (cyc_len == LEN_NONE)
                    cyc_len = LEN_ONE;
                else
                    cyc_len = LEN_MANY;
            end
            ACT_CLOSE:
            begin
                if (cyc_len == LEN_NONE)
                    ans.status = ST_EMPTY;
                else if (cyc_len == LEN_ONE)
                    ans.status = ST_SINGLE;
                else
                    link_literals(cyc_tail, cyc_head);
                cyc_len = LEN_NONE;
            end
            ACT_QUERY:
            begin
                if (img_set[lit])
                begin
                    ans.image = img_map[lit];
                end
                else
                begin
                    ans.image         = lit;
                    ans.image_trivial = 1'b1;
                end
                if (inv_set[lit])
                begin
                    ans.inverse = inv_map[lit];
                end
                else
                begin
                    ans.inverse         = lit;
                    ans.inverse_trivial = 1'b1;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // mostly a small pool so that links get revisited and overwritten
    function automatic lit_t pick_literal();
        if ($urandom_range(0, 2) == 0)
            return lit_t'($urandom_range(0, TABLE_DEPTH - 1));
        return lit_t'($urandom_range(0, 31));
    endfunction

    task automatic send_word(input action_t act, input lit_t lit);
        int           gap_pct;
        perm_answer_t ans;
        gap_pct = (idle_mode == IDLE_SEND) ? 49 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.action  <= act;
        cmd_ch.literal <= lit;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        ans = predict_answer(act, lit);
        pending_answers = {pending_answers, ans};
        n_words++;
        if (act == ACT_QUERY)
            n_queries++;
        if (act == ACT_CLOSE)
        begin
            if (ans.status == ST_EMPTY)
                n_empty++;
            else if (ans.status == ST_SINGLE)
                n_single++;
            else
                n_cycles++;
        end
    endtask

    // stop offering the last word, then wait for every answer
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        idle_mode = IDLE_NONE;
        send_word(ACT_QUERY, lit_t'(0));
        send_word(ACT_QUERY, lit_t'(TABLE_DEPTH - 1));
    endtask

    task automatic test_cycle_links();
        idle_mode = IDLE_NONE;
        send_word(ACT_ADD, lit_t'(0));
        send_word(ACT_ADD, lit_t'(TABLE_DEPTH - 1));
        send_word(ACT_ADD, lit_t'(5));
        send_word(ACT_CLOSE, lit_t'(TABLE_DEPTH - 1));
        send_word(ACT_QUERY, lit_t'(0));
        send_word(ACT_QUERY, lit_t'(TABLE_DEPTH - 1));
        send_word(ACT_QUERY, lit_t'(5));
        // partial links are visible while the cycle is still open
        send_word(ACT_ADD, lit_t'(12));
        send_word(ACT_ADD, lit_t'(13));
        send_word(ACT_QUERY, lit_t'(12));
        send_word(ACT_CLOSE, lit_t'(0));
        send_word(ACT_QUERY, lit_t'(12));
    endtask

    task automatic test_special_cases();
        idle_mode = IDLE_NONE;
        send_word(ACT_CLOSE, lit_t'(0));
        send_word(ACT_ADD, lit_t'(7));
        send_word(ACT_CLOSE, lit_t'(7));
        send_word(ACT_QUERY, lit_t'(7));
        // repeated literal links to itself
        send_word(ACT_ADD, lit_t'(3));
        send_word(ACT_ADD, lit_t'(3));
        send_word(ACT_CLOSE, lit_t'(3));
        send_word(ACT_QUERY, lit_t'(3));
        send_word(ACT_UNUSED, lit_t'(TABLE_DEPTH - 1));
        send_word(ACT_QUERY, lit_t'(TABLE_DEPTH - 1));
    endtask

    task automatic test_random(input idle_mode_t mode, input int n_items);
        int   start;
        int   kind;
        int   len;
        lit_t members[$];
        lit_t lit;
        idle_mode = mode;
        start = n_words;
        while (n_words - start < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                len = $urandom_range(2, 6);
                members.delete();
                repeat (len)
                begin
                    lit = pick_literal();
                    members = {members, lit};
                    send_word(ACT_ADD, lit);
                end
                if ($urandom_range(0, 3) == 0)
                    send_word(ACT_QUERY, members[$urandom_range(0, len - 1)]);
                send_word(ACT_CLOSE, pick_literal());
                repeat ($urandom_range(1, 4))
                    send_word(ACT_QUERY, members[$urandom_range(0, len - 1)]);
            end
            else if (kind < 80)
            begin
                send_word(ACT_QUERY, pick_literal());
            end
            else if (kind < 88)
            begin
                send_word(ACT_ADD, pick_literal());
                send_word(ACT_CLOSE, pick_literal());
            end
            else if (kind < 93)
            begin
                send_word(ACT_CLOSE, pick_literal());
            end
            else
            begin
                send_word(action_t'($urandom_range(0, 3)),
                          lit_t'($urandom_range(0, TABLE_DEPTH - 1)));
            end
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        idle_mode = IDLE_NONE;
        hold_req  = 1'b1;
        repeat (24)
            send_word(action_t'($urandom_range(0, 2)), pick_literal());
    endtask

    // response side ready, with the long hold-off counted here
    initial
    begin
        int stall_pct;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall_pct = (idle_mode == IDLE_RECV) ? 49 : (idle_mode == IDLE_BOTH) ? 6 : 0;
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("response word with nothing pending");
                n_errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp_ch.image !== want.image)
                begin
                    $error("image: expected %0d, got %0d", want.image, rsp_ch.image);
                    n_errors++;
                end
                if (rsp_ch.inverse !== want.inverse)
                begin
                    $error("inverse: expected %0d, got %0d", want.inverse, rsp_ch.inverse);
                    n_errors++;
                end
                if (rsp_ch.image_trivial !== want.image_trivial)
                begin
                    $error("image_trivial: expected %0d, got %0d",
                           want.image_trivial, rsp_ch.image_trivial);
                    n_errors++;
                end
                if (rsp_ch.inverse_trivial !== want.inverse_trivial)
                begin
                    $error("inverse_trivial: expected %0d, got %0d",
                           want.inverse_trivial, rsp_ch.inverse_trivial);
                    n_errors++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    n_errors++;
                end
            end
        end
    end

    // covers the clearing sweep after reset and the long hold-off
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("no word moved for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, pending_answers.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.action  <= ACT_ADD;
        cmd_ch.literal <= '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_cycle_links();
        test_special_cases();
        test_random(IDLE_NONE, 400);
        test_random(IDLE_SEND, 400);
        test_random(IDLE_RECV, 400);
        test_random(IDLE_BOTH, 450);
        test_backpressure();

        cmd_ch.valid <= 1'b0;
        wait_drained();
        repeat (8)
            @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            $error("%0d responses never arrived", pending_answers.size());
            n_errors++;
        end

        $display("sent %0d commands: %0d lookups, %0d cycles closed", n_words, n_queries,
                 n_cycles);
        $display("empty closes %0d, dropped one-element cycles %0d, mismatches %0d",
                 n_empty, n_single, n_errors);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
